// ----- hdl/dpc_pkg.sv -----
// Package with the codes, register layout and structs of the device pairing controller.
package dpc_pkg;

	typedef logic [2:0] mode_t;
	typedef logic [2:0] req_t;
	typedef logic [1:0] action_t;
	typedef logic [2:0] led_t;
	typedef logic [1:0] reg_idx_t;

	localparam mode_t MODE_STARTUP    = 3'd0;
	localparam mode_t MODE_SLEEP      = 3'd1;
	localparam mode_t MODE_NOT_PAIRED = 3'd2;
	localparam mode_t MODE_PAIRING    = 3'd3;
	localparam mode_t MODE_AWAIT      = 3'd4;
	localparam mode_t MODE_PAIRED     = 3'd5;

	localparam req_t REQ_BEGIN     = 3'd0;
	localparam req_t REQ_BUTTON    = 3'd1;
	localparam req_t REQ_DISCOVERY = 3'd2;
	localparam req_t REQ_PAIR_RSP  = 3'd3;
	localparam req_t REQ_TICK      = 3'd4;
	localparam req_t REQ_CONTROL   = 3'd5;
	localparam req_t REQ_APP_DATA  = 3'd6;

	localparam action_t ACT_NONE     = 2'd0;
	localparam action_t ACT_BCAST    = 2'd1;
	localparam action_t ACT_PAIR_REQ = 2'd2;
	localparam action_t ACT_APP      = 2'd3;

	localparam led_t LED_NONE     = 3'd0;
	localparam led_t LED_OFF      = 3'd1;
	localparam led_t LED_UNPAIRED = 3'd2;
	localparam led_t LED_PAIRING  = 3'd3;
	localparam led_t LED_PAIRED   = 3'd4;

	localparam reg_idx_t REG_BCAST_PERIOD   = 2'd0;
	localparam reg_idx_t REG_CONFIRM_TIMEOUT = 2'd1;
	localparam reg_idx_t REG_TOP_CHANNEL    = 2'd2;

	localparam logic [7:0] RST_BCAST_PERIOD    = 8'd1;
	localparam logic [7:0] RST_CONFIRM_TIMEOUT = 8'd10;
	localparam logic [3:0] RST_TOP_CHANNEL     = 4'd14;
	localparam logic [3:0] RST_CHANNEL         = 4'd1;
	localparam logic [7:0] TICK_MAX            = 8'hFF;

	typedef struct packed {
		logic [7:0] bcast_period;
		logic [7:0] confirm_timeout;
		logic [3:0] top_channel;
	} dpc_cfg_t;

	typedef struct packed {
		req_t        req_type;
		logic        wake_up;
		logic        long_press;
		logic [3:0]  offer_channel;
		logic [47:0] source_addr;
	} dpc_event_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  channel;
		logic [47:0] stored_peer;
		logic [3:0]  stored_channel;
		logic [47:0] session_peer;
		logic [7:0]  tick_count;
	} dpc_state_t;

	typedef struct packed {
		mode_t       mode;
		mode_t       prev_mode;
		logic        mode_changed;
		action_t     action;
		logic [3:0]  radio_channel;
		logic [47:0] session_addr;
		led_t        led_pattern;
	} dpc_result_t;

endpackage

// ----- hdl/dpc_if.sv -----
// Stream interfaces for the event transfers in and the result transfers out.
interface dpc_req_if;
	import dpc_pkg::*;
	logic        valid;
	logic        ready;
	req_t        req_type;
	logic        wake_up;
	logic        long_press;
	logic [3:0]  offer_channel;
	logic [47:0] source_addr;
	modport source (output valid, req_type, wake_up, long_press, offer_channel, source_addr,
		input ready);
	modport sink (input valid, req_type, wake_up, long_press, offer_channel, source_addr,
		output ready);
endinterface

interface dpc_rsp_if;
	import dpc_pkg::*;
	logic        valid;
	logic        ready;
	mode_t       mode;
	mode_t       prev_mode;
	logic        mode_changed;
	action_t     action;
	logic [3:0]  radio_channel;
	logic [47:0] session_addr;
	led_t        led_pattern;
	modport source (output valid, mode, prev_mode, mode_changed, action, radio_channel,
		session_addr, led_pattern, input ready);
	modport sink (input valid, mode, prev_mode, mode_changed, action, radio_channel,
		session_addr, led_pattern, output ready);
endinterface

// ----- hdl/device_pairing_controller.sv -----
// Top level of the device pairing controller: APB registers, event stage and result queue.
//
// Channel  Direction  Transfer
// req      in         one event: req_type, wake_up, long_press, offer_channel, source_addr
// rsp      out        one result per event: mode, prev_mode, mode_changed, action,
//                     radio_channel, session_addr, led_pattern
// apb      in/out     register writes and reads, pready always high
//
// An event transfer is taken into the input stage and its result is written into the
// result queue at the next edge, from which the result is offered.
// The controller accepts one event per cycle while input ready is high.
// Input ready drops while the input stage and the two-entry result queue together hold
// two results and no result transfer happens in that cycle.
// Reset returns the registers to their defaults and the mode to startup.
module device_pairing_controller (
	input  logic              clk,
	input  logic              arst_n,
	dpc_req_if.sink           req,
	dpc_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import dpc_pkg::*;

	dpc_cfg_t    cfg_q;
	dpc_state_t  st_q;
	dpc_state_t  st_next;
	dpc_event_t  ev_s1;
	logic        valid_s1;
	dpc_result_t res;
	dpc_result_t res_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic [1:0]  occ;
	logic        pop;
	logic        accept;
	reg_idx_t    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bcast_period    <= RST_BCAST_PERIOD;
			cfg_q.confirm_timeout <= RST_CONFIRM_TIMEOUT;
			cfg_q.top_channel     <= RST_TOP_CHANNEL;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_BCAST_PERIOD:    cfg_q.bcast_period    <= pwdata[7:0];
				REG_CONFIRM_TIMEOUT: cfg_q.confirm_timeout <= pwdata[7:0];
				REG_TOP_CHANNEL:     cfg_q.top_channel     <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BCAST_PERIOD:    prdata = {24'd0, cfg_q.bcast_period};
			REG_CONFIRM_TIMEOUT: prdata = {24'd0, cfg_q.confirm_timeout};
			REG_TOP_CHANNEL:     prdata = {28'd0, cfg_q.top_channel};
			default:             prdata = '0;
		endcase
	end

	assign pop       = rsp.valid && rsp.ready;
	assign occ       = count_q + {1'b0, valid_s1};
	assign req.ready = (occ < 2'd2) || pop;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1.req_type      <= req.req_type;
			ev_s1.wake_up       <= req.wake_up;
			ev_s1.long_press    <= req.long_press;
			ev_s1.offer_channel <= req.offer_channel;
			ev_s1.source_addr   <= req.source_addr;
		end
	end

	dpc_step u_step (
		.ev      (ev_s1),
		.st      (st_q),
		.cfg     (cfg_q),
		.st_next (st_next),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode           <= MODE_STARTUP;
			st_q.channel        <= RST_CHANNEL;
			st_q.stored_peer    <= '0;
			st_q.stored_channel <= '0;
			st_q.session_peer   <= '0;
			st_q.tick_count     <= '0;
		end else if (valid_s1) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

	assign rsp.valid         = (count_q != 2'd0);
	assign rsp.mode          = res_q[rd_ptr_q].mode;
	assign rsp.prev_mode     = res_q[rd_ptr_q].prev_mode;
	assign rsp.mode_changed  = res_q[rd_ptr_q].mode_changed;
	assign rsp.action        = res_q[rd_ptr_q].action;
	assign rsp.radio_channel = res_q[rd_ptr_q].radio_channel;
	assign rsp.session_addr  = res_q[rd_ptr_q].session_addr;
	assign rsp.led_pattern   = res_q[rd_ptr_q].led_pattern;

endmodule

// ----- hdl/dpc_step.sv -----
// Next-state and result logic for one event of the pairing controller.
module dpc_step (
	input  dpc_pkg::dpc_event_t  ev,
	input  dpc_pkg::dpc_state_t  st,
	input  dpc_pkg::dpc_cfg_t    cfg,
	output dpc_pkg::dpc_state_t  st_next,
	output dpc_pkg::dpc_result_t res
);
	import dpc_pkg::*;

	logic [4:0] ch_inc;
	logic [3:0] ch_next;

	assign ch_inc  = {1'b0, st.channel} + 5'd1;
	assign ch_next = (ch_inc > {1'b0, cfg.top_channel}) ? 4'd1 : ch_inc[3:0];

	always_comb begin
		dpc_state_t s;
		mode_t      old;
		mode_t      nm;
		logic       go;
		logic       restore;
		action_t    act;
		led_t       led;

		s       = st;
		nm      = st.mode;
		go      = 1'b0;
		restore = 1'b0;
		act     = ACT_NONE;
		led     = LED_NONE;

		if (ev.req_type == REQ_BEGIN && ev.wake_up) begin
			s.mode = MODE_SLEEP;
		end
		old = s.mode;

		unique case (ev.req_type)
			REQ_BEGIN: begin
				restore = 1'b1;
			end
			REQ_BUTTON: begin
				if (old == MODE_NOT_PAIRED || old == MODE_PAIRED) begin
					if (ev.long_press) begin
						go = 1'b1;
						nm = MODE_PAIRING;
					end
				end else if (old == MODE_PAIRING || old == MODE_AWAIT) begin
					if (ev.long_press) begin
						s.stored_peer = '0;
					end
					restore = 1'b1;
				end
			end
			REQ_DISCOVERY: begin
				if (old == MODE_PAIRING) begin
					s.channel      = ev.offer_channel;
					s.session_peer = ev.source_addr;
					act            = ACT_PAIR_REQ;
					go             = 1'b1;
					nm             = MODE_AWAIT;
				end
			end
			REQ_PAIR_RSP: begin
				if (old == MODE_AWAIT) begin
					s.stored_channel = s.channel;
					s.stored_peer    = ev.source_addr;
					go               = 1'b1;
					nm               = MODE_PAIRED;
				end
			end
			REQ_TICK: begin
				if (old == MODE_PAIRING || old == MODE_AWAIT) begin
					if (s.tick_count != TICK_MAX) begin
						s.tick_count = s.tick_count + 8'd1;
					end
					if (old == MODE_PAIRING) begin
						if (s.tick_count >= cfg.bcast_period) begin
							s.tick_count = '0;
							s.channel    = ch_next;
							act          = ACT_BCAST;
						end
					end else if (s.tick_count >= cfg.confirm_timeout) begin
						go = 1'b1;
						nm = MODE_NOT_PAIRED;
					end
				end
			end
			REQ_APP_DATA: begin
				act = ACT_APP;
			end
			default: begin
			end
		endcase

		if (restore) begin
			go = 1'b1;
			if (s.stored_peer != '0) begin
				s.channel      = s.stored_channel;
				s.session_peer = s.stored_peer;
				nm             = MODE_PAIRED;
			end else begin
				nm = MODE_NOT_PAIRED;
			end
		end

		if (go && nm != old) begin
			led = LED_OFF;
			if (old == MODE_PAIRED) begin
				s.session_peer = '0;
			end
			unique case (nm)
				MODE_NOT_PAIRED: begin
					led = LED_UNPAIRED;
				end
				MODE_PAIRING: begin
					led          = LED_PAIRING;
					s.tick_count = '0;
					s.channel    = ch_next;
					act          = ACT_BCAST;
				end
				MODE_AWAIT: begin
					led          = LED_PAIRING;
					s.tick_count = '0;
				end
				MODE_PAIRED: begin
					if (old != MODE_SLEEP) begin
						led = LED_PAIRED;
					end
				end
				default: begin
				end
			endcase
			s.mode = nm;
		end

		st_next           = s;
		res.mode          = s.mode;
		res.prev_mode     = old;
		res.mode_changed  = (s.mode != old);
		res.action        = act;
		res.radio_channel = s.channel;
		res.session_addr  = s.session_peer;
		res.led_pattern   = led;
	end

endmodule

// ----- hdl/dpc_checker.sv -----
// Port-level checks of the device pairing controller and their binding to the top level.
module dpc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input dpc_pkg::mode_t    mode,
	input dpc_pkg::mode_t    prev_mode,
	input logic              mode_changed,
	input dpc_pkg::action_t  action,
	input dpc_pkg::led_t     led_pattern,
	input logic [47:0]       session_addr
);
	import dpc_pkg::*;

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode_changed == (mode != prev_mode)))
		else $error("mode_changed does not match the mode transition");

	a_led_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mode_changed) |-> (led_pattern == LED_NONE))
		else $error("LED pattern sent without a mode change");

	a_pair_req: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == ACT_PAIR_REQ) |->
		(mode == MODE_AWAIT && prev_mode == MODE_PAIRING))
		else $error("pairing request outside the pairing to awaiting transition");

	a_peer_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && prev_mode == MODE_PAIRED && mode != MODE_PAIRED) |->
		(session_addr == '0))
		else $error("session peer kept after leaving paired mode");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(mode) && $stable(action)))
		else $error("stalled result transfer changed");

endmodule

bind device_pairing_controller dpc_checker u_dpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.mode         (rsp.mode),
	.prev_mode    (rsp.prev_mode),
	.mode_changed (rsp.mode_changed),
	.action       (rsp.action),
	.led_pattern  (rsp.led_pattern),
	.session_addr (rsp.session_addr)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the device pairing controller: directed table, random events.
`timescale 1ns / 100ps

module testbench;
	import dpc_pkg::*;

	localparam req_t        REQ_UNUSED   = 3'd7;
	localparam logic [47:0] ADDR_MAX     = 48'hFFFF_FFFF_FFFF;
	localparam int          N_DIRECTED   = 26;
	localparam int          N_PHASES     = 6;
	localparam int          PHASE_ITEMS  = 225;
	localparam int          RX_HOLD_AT   = 300;
	localparam int          RX_HOLD_LEN  = 80;

	typedef struct packed {
		dpc_event_t  ev;
		logic        typed;
		dpc_result_t want;
	} stim_row_t;

	localparam dpc_result_t NO_RESULT = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dpc_req_if req_ch ();
	dpc_rsp_if rsp_ch ();

	device_pairing_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	dpc_state_t  node;
	dpc_cfg_t    node_cfg;
	dpc_result_t pending_results [$];
	stim_row_t   directed [N_DIRECTED];
	int          error_count = 0;
	int          sent_count = 0;
	bit          sender_steady = 1'b0;

	task automatic flag_error(input string what);
		$display("ERROR at %0t: %s", $time, what);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [47:0] got,
		input logic [47:0] want);
		if (got !== want) begin
			flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	function automatic void hop_channel(inout action_t act);
		logic [4:0] c;
		c = {1'b0, node.channel} + 5'd1;
		if (c > {1'b0, node_cfg.top_channel}) c = 5'd1;
		node.channel = c[3:0];
		act = ACT_BCAST;
	endfunction

	function automatic void switch_mode(input mode_t nm, inout led_t led, inout action_t act);
		mode_t old;
		old = node.mode;
		if (old == nm) return;
		led = LED_OFF;
		if (old == MODE_PAIRED) node.session_peer = '0;
		unique case (nm)
			MODE_NOT_PAIRED: led = LED_UNPAIRED;
			MODE_PAIRING: begin
				led = LED_PAIRING;
				node.tick_count = '0;
				hop_channel(act);
			end
			MODE_AWAIT: begin
				led = LED_PAIRING;
				node.tick_count = '0;
			end
			MODE_PAIRED: begin
				if (old != MODE_SLEEP) led = LED_PAIRED;
			end
			default: ;
		endcase
		node.mode = nm;
	endfunction

	function automatic void restore_peer(inout led_t led, inout action_t act);
		if (node.stored_peer != '0) begin
			node.channel = node.stored_channel;
			node.session_peer = node.stored_peer;
			switch_mode(MODE_PAIRED, led, act);
		end else begin
			switch_mode(MODE_NOT_PAIRED, led, act);
		end
	endfunction

	function automatic dpc_result_t predict_event(input dpc_event_t ev);
		dpc_result_t r;
		led_t        led;
		action_t     act;
		mode_t       prev;
		led = LED_NONE;
		act = ACT_NONE;
		if (ev.req_type == REQ_BEGIN && ev.wake_up) node.mode = MODE_SLEEP;
		prev = node.mode;
		unique case (ev.req_type)
			REQ_BEGIN: restore_peer(led, act);
			REQ_BUTTON: begin
				if (node.mode == MODE_NOT_PAIRED || node.mode == MODE_PAIRED) begin
					if (ev.long_press) switch_mode(MODE_PAIRING, led, act);
				end else if (node.mode == MODE_PAIRING || node.mode == MODE_AWAIT) begin
					if (ev.long_press) node.stored_peer = '0;
					restore_peer(led, act);
				end
			end
			REQ_DISCOVERY: begin
				if (node.mode == MODE_PAIRING) begin
					node.channel = ev.offer_channel;
					node.session_peer = ev.source_addr;
					act = ACT_PAIR_REQ;
					switch_mode(MODE_AWAIT, led, act);
				end
			end
			REQ_PAIR_RSP: begin
				if (node.mode == MODE_AWAIT) begin
					node.stored_channel = node.channel;
					node.stored_peer = ev.source_addr;
					switch_mode(MODE_PAIRED, led, act);
				end
			end
			REQ_TICK: begin
				if (node.mode == MODE_PAIRING || node.mode == MODE_AWAIT) begin
					if (node.tick_count != TICK_MAX) node.tick_count = node.tick_count + 8'd1;
					if (node.mode == MODE_PAIRING) begin
						if (node.tick_count >= node_cfg.bcast_period) begin
							node.tick_count = '0;
							hop_channel(act);
						end
					end else if (node.tick_count >= node_cfg.confirm_timeout) begin
						switch_mode(MODE_NOT_PAIRED, led, act);
					end
				end
			end
			REQ_APP_DATA: act = ACT_APP;
			default: ;
		endcase
		r.mode = node.mode;
		r.prev_mode = prev;
		r.mode_changed = (node.mode != prev);
		r.action = act;
		r.radio_channel = node.channel;
		r.session_addr = node.session_peer;
		r.led_pattern = led;
		return r;
	endfunction

	function automatic dpc_event_t make_event(input req_t rq, input logic wake,
		input logic lng, input logic [3:0] hub, input logic [47:0] src);
		dpc_event_t ev;
		ev.req_type = rq;
		ev.wake_up = wake;
		ev.long_press = lng;
		ev.offer_channel = hub;
		ev.source_addr = src;
		return ev;
	endfunction

	function automatic dpc_result_t make_result(input mode_t m, input mode_t p,
		input action_t a, input logic [3:0] ch, input logic [47:0] peer, input led_t led);
		dpc_result_t r;
		r.mode = m;
		r.prev_mode = p;
		r.mode_changed = (m != p);
		r.action = a;
		r.radio_channel = ch;
		r.session_addr = peer;
		r.led_pattern = led;
		return r;
	endfunction

	function automatic dpc_event_t draw_event();
		dpc_event_t  ev;
		logic [63:0] wide;
		int          pick;
		int          roll;
		wide = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		ev.wake_up = 1'($urandom);
		ev.long_press = 1'($urandom);
		ev.offer_channel = 4'($urandom);
		ev.source_addr = (pick == 0) ? 48'd0 : (pick == 1) ? ADDR_MAX : wide[47:0];
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) begin
			ev.req_type = req_t'($urandom_range(0, 7));
		end else begin
			unique case (node.mode)
				MODE_NOT_PAIRED: begin
					ev.req_type = (roll < 80) ? REQ_BUTTON : (roll < 90) ? REQ_BEGIN : REQ_APP_DATA;
					ev.long_press = 1'b1;
				end
				MODE_PAIRING: begin
					ev.req_type = (roll < 50) ? REQ_TICK : (roll < 85) ? REQ_DISCOVERY :
						(roll < 95) ? REQ_BUTTON : REQ_APP_DATA;
				end
				MODE_AWAIT: begin
					ev.req_type = (roll < 40) ? REQ_PAIR_RSP : (roll < 85) ? REQ_TICK :
						(roll < 95) ? REQ_BUTTON : REQ_BEGIN;
				end
				MODE_PAIRED: begin
					ev.req_type = (roll < 40) ? REQ_APP_DATA : (roll < 80) ? REQ_BUTTON : REQ_BEGIN;
					if (ev.req_type == REQ_BUTTON) ev.long_press = 1'b1;
				end
				default: ev.req_type = REQ_BEGIN;
			endcase
		end
		return ev;
	endfunction

	task automatic send_event(input dpc_event_t ev, input logic typed, input dpc_result_t want);
		int          gap;
		dpc_result_t predicted;
		if (sent_count % 50 == 0) sender_steady = ($urandom_range(0, 3) == 0);
		sent_count++;
		gap = sender_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		req_ch.req_type <= ev.req_type;
		req_ch.wake_up <= ev.wake_up;
		req_ch.long_press <= ev.long_press;
		req_ch.offer_channel <= ev.offer_channel;
		req_ch.source_addr <= ev.source_addr;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = predict_event(ev);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_register(input reg_idx_t idx, input logic [31:0] want);
		logic [31:0] rdata;
		logic [31:0] mask;
		mask = (idx == REG_TOP_CHANNEL) ? 32'h0000_000F : 32'h0000_00FF;
		apb_access(1'b0, idx, 32'd0, rdata);
		if ((rdata & mask) !== want) begin
			flag_error($sformatf("register %0d reads %0h, expected %0h", idx, rdata & mask, want));
		end
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] unused;
		apb_access(1'b1, idx, val, unused);
		unique case (idx)
			REG_BCAST_PERIOD:    node_cfg.bcast_period = val[7:0];
			REG_CONFIRM_TIMEOUT: node_cfg.confirm_timeout = val[7:0];
			default:             node_cfg.top_channel = val[3:0];
		endcase
		check_register(idx, val);
	endtask

	initial begin : result_sink
		int          w;
		int          results_seen;
		bit          steady;
		bit          held;
		dpc_result_t got;
		dpc_result_t want;
		rsp_ch.ready = 1'b0;
		results_seen = 0;
		steady = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen % 50 == 0) steady = ($urandom_range(0, 3) == 0);
			if (!held && results_seen == RX_HOLD_AT) begin
				held = 1'b1;
				w = RX_HOLD_LEN;
			end else begin
				w = steady ? 0 : $urandom_range(0, 4);
			end
			if (w > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end else begin
				@(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got.mode = rsp_ch.mode;
			got.prev_mode = rsp_ch.prev_mode;
			got.mode_changed = rsp_ch.mode_changed;
			got.action = rsp_ch.action;
			got.radio_channel = rsp_ch.radio_channel;
			got.session_addr = rsp_ch.session_addr;
			got.led_pattern = rsp_ch.led_pattern;
			if (pending_results.size() == 0) begin
				flag_error("result transfer with no pending expectation");
			end else begin
				want = pending_results.pop_front();
				compare_field("mode", 48'(got.mode), 48'(want.mode));
				compare_field("prev_mode", 48'(got.prev_mode), 48'(want.prev_mode));
				compare_field("mode_changed", 48'(got.mode_changed), 48'(want.mode_changed));
				compare_field("action", 48'(got.action), 48'(want.action));
				compare_field("radio_channel", 48'(got.radio_channel), 48'(want.radio_channel));
				compare_field("session_addr", got.session_addr, want.session_addr);
				compare_field("led_pattern", 48'(got.led_pattern), 48'(want.led_pattern));
			end
			results_seen++;
		end
	end

	initial begin : stimulus
		dpc_cfg_t settings [N_PHASES];

		directed[0]  = {make_event(REQ_BUTTON, 1'b0, 1'b1, 4'd0, 48'd0), 1'b1,
			make_result(MODE_STARTUP, MODE_STARTUP, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[1]  = {make_event(REQ_BUTTON, 1'b1, 1'b0, 4'd15, ADDR_MAX), 1'b1,
			make_result(MODE_STARTUP, MODE_STARTUP, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[2]  = {make_event(REQ_BEGIN, 1'b0, 1'b0, 4'd0, 48'd0), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_STARTUP, ACT_NONE, 4'd1, 48'd0, LED_UNPAIRED)};
		directed[3]  = {make_event(REQ_DISCOVERY, 1'b0, 1'b0, 4'd15, ADDR_MAX), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[4]  = {make_event(REQ_PAIR_RSP, 1'b0, 1'b0, 4'd0, ADDR_MAX), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[5]  = {make_event(REQ_TICK, 1'b0, 1'b0, 4'd0, 48'd0), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[6]  = {make_event(REQ_CONTROL, 1'b1, 1'b1, 4'd15, ADDR_MAX), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[7]  = {make_event(REQ_UNUSED, 1'b1, 1'b1, 4'd15, ADDR_MAX), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[8]  = {make_event(REQ_APP_DATA, 1'b0, 1'b0, 4'd0, ADDR_MAX), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_APP, 4'd1, 48'd0, LED_NONE)};
		directed[9]  = {make_event(REQ_BEGIN, 1'b0, 1'b0, 4'd0, 48'd0), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[10] = {make_event(REQ_BUTTON, 1'b0, 1'b0, 4'd0, 48'd0), 1'b1,
			make_result(MODE_NOT_PAIRED, MODE_NOT_PAIRED, ACT_NONE, 4'd1, 48'd0, LED_NONE)};
		directed[11] = {make_event(REQ_BUTTON, 1'b0, 1'b1, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[12] = {make_event(REQ_TICK, 1'b0, 1'b0, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[13] = {make_event(REQ_DISCOVERY, 1'b0, 1'b0, 4'd15, ADDR_MAX), 1'b0, NO_RESULT};
		directed[14] = {make_event(REQ_PAIR_RSP, 1'b0, 1'b0, 4'd0, ADDR_MAX), 1'b0, NO_RESULT};
		directed[15] = {make_event(REQ_BEGIN, 1'b1, 1'b0, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[16] = {make_event(REQ_APP_DATA, 1'b0, 1'b0, 4'd0, 48'h1), 1'b0, NO_RESULT};
		directed[17] = {make_event(REQ_BUTTON, 1'b0, 1'b1, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[18] = {make_event(REQ_BUTTON, 1'b0, 1'b0, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[19] = {make_event(REQ_BUTTON, 1'b0, 1'b1, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[20] = {make_event(REQ_DISCOVERY, 1'b0, 1'b0, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[21] = {make_event(REQ_BUTTON, 1'b0, 1'b1, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[22] = {make_event(REQ_BEGIN, 1'b1, 1'b0, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[23] = {make_event(REQ_BUTTON, 1'b0, 1'b1, 4'd0, 48'd0), 1'b0, NO_RESULT};
		directed[24] = {make_event(REQ_DISCOVERY, 1'b0, 1'b0, 4'd3, 48'h0123_4567_89AB), 1'b0,
			NO_RESULT};
		directed[25] = {make_event(REQ_BUTTON, 1'b0, 1'b0, 4'd0, 48'd0), 1'b0, NO_RESULT};

		settings[0] = {8'd1, 8'd1, 4'd15};
		settings[1] = {8'd255, 8'd255, 4'd1};
		settings[2] = {8'd0, 8'd0, 4'd0};
		settings[3] = {8'd2, 8'd3, 4'd14};
		for (int p = 4; p < N_PHASES; p++) begin
			settings[p].bcast_period = 8'($urandom_range(1, 6));
			settings[p].confirm_timeout = 8'($urandom_range(1, 12));
			settings[p].top_channel = 4'($urandom_range(1, 15));
		end

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_BEGIN;
		req_ch.wake_up = 1'b0;
		req_ch.long_press = 1'b0;
		req_ch.offer_channel = 4'd0;
		req_ch.source_addr = 48'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 32'd0;

		node = '0;
		node.mode = MODE_STARTUP;
		node.channel = RST_CHANNEL;
		node_cfg = {RST_BCAST_PERIOD, RST_CONFIRM_TIMEOUT, RST_TOP_CHANNEL};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		check_register(REG_BCAST_PERIOD, 32'(RST_BCAST_PERIOD));
		check_register(REG_CONFIRM_TIMEOUT, 32'(RST_CONFIRM_TIMEOUT));
		check_register(REG_TOP_CHANNEL, 32'(RST_TOP_CHANNEL));

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_event(directed[i].ev, directed[i].typed, directed[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			write_register(REG_BCAST_PERIOD, 32'(settings[p].bcast_period));
			write_register(REG_CONFIRM_TIMEOUT, 32'(settings[p].confirm_timeout));
			write_register(REG_TOP_CHANNEL, 32'(settings[p].top_channel));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_event(draw_event(), 1'b0, NO_RESULT);
				if (i == PHASE_ITEMS / 2) wait_drained();
			end
		end

		wait_drained();
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/dpc_pkg.sv
hdl/dpc_if.sv
hdl/dpc_step.sv
hdl/device_pairing_controller.sv
hdl/dpc_checker.sv
tb/testbench.sv
